// ===== hdl/lcdw_pkg.sv =====
// Shared types, register map and power-up tables for the LCD nibble write sequencer.
// No dependencies; every file in hdl but lcdw_fifo imports this package.
package lcdw_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int ADDR_W            = 5;
    localparam int DATA_W            = 32;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_ENABLE_PHASE = 3'd0;
    localparam logic [2:0] REG_SELECT_SETUP = 3'd1;
    localparam logic [2:0] REG_BYTE_GAP     = 3'd2;
    localparam logic [2:0] REG_SHORT_WAIT   = 3'd3;
    localparam logic [2:0] REG_LONG_WAIT    = 3'd4;
    localparam logic [2:0] REG_DATA_WAIT    = 3'd5;

    localparam logic [7:0]  RST_ENABLE_PHASE = 8'd10;
    localparam logic [15:0] RST_SELECT_SETUP = 16'd1000;
    localparam logic [15:0] RST_BYTE_GAP     = 16'd100;
    localparam logic [15:0] RST_SHORT_WAIT   = 16'd40;
    localparam logic [15:0] RST_LONG_WAIT    = 16'd1070;
    localparam logic [15:0] RST_DATA_WAIT    = 16'd1000;

    localparam logic [3:0]  INIT_COUNT   = 4'd8;
    localparam logic [15:0] INIT_LEAD_US = 16'd30000;
    localparam logic [7:0]  LONG_CMD_LIMIT = 8'd4;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_CMD  = 2'd1,
        KIND_DATA = 2'd2,
        KIND_INIT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_value;
    } t_item;

    typedef struct packed {
        logic       select_pin;
        logic       enable_pin;
        logic [3:0] bus_nibble;
        logic       busy_res;
        logic       rejected;
    } t_result;

    typedef struct packed {
        logic [7:0]  enable_phase_us;
        logic [15:0] select_setup_us;
        logic [15:0] byte_gap_us;
        logic [15:0] short_command_wait_us;
        logic [15:0] long_command_wait_us;
        logic [15:0] data_wait_us;
    } t_cfg;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_SETUP     = 12'b0000_0000_0010,
        PH_HI_A      = 12'b0000_0000_0100,
        PH_HI_B      = 12'b0000_0000_1000,
        PH_HI_C      = 12'b0000_0001_0000,
        PH_LO_A      = 12'b0000_0010_0000,
        PH_LO_B      = 12'b0000_0100_0000,
        PH_LO_C      = 12'b0000_1000_0000,
        PH_GAP       = 12'b0001_0000_0000,
        PH_POST      = 12'b0010_0000_0000,
        PH_INIT_LEAD = 12'b0100_0000_0000,
        PH_INIT_TAIL = 12'b1000_0000_0000
    } t_phase;

    localparam int ITEM_W   = $bits(t_item);
    localparam int RESULT_W = $bits(t_result);

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h30;
            3'd1:    c = 8'h30;
            3'd2:    c = 8'h30;
            3'd3:    c = 8'h20;
            3'd4:    c = 8'h28;
            3'd5:    c = 8'h0F;
            3'd6:    c = 8'h01;
            default: c = 8'h06;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] init_tail(input logic [2:0] idx);
        logic [15:0] t;
        case (idx)
            3'd0:    t = 16'd10000;
            3'd1:    t = 16'd1000;
            3'd2:    t = 16'd1000;
            3'd3:    t = 16'd1000;
            3'd4:    t = 16'd100;
            3'd5:    t = 16'd100;
            3'd6:    t = 16'd100;
            default: t = 16'd10000;
        endcase
        return t;
    endfunction

endpackage

// ===== hdl/lcdw_fifo.sv =====
// Two-entry queue with registered slots.
// Depends on nothing but its WIDTH parameter.
module lcdw_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
    a_pop_moves_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_pop |=> r_rd_ptr != $past(r_rd_ptr))
        else $error("read pointer did not advance on pop");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_push && !w_do_pop) |=> r_count == $past(r_count) + 2'd1)
        else $error("count did not follow push");
`endif

endmodule

// ===== hdl/lcdw_regs.sv =====
// Configuration registers behind an APB-style port.
// Depends on lcdw_pkg for the register map and reset values.
module lcdw_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lcdw_pkg::ADDR_W-1:0] paddr,
    input  logic [lcdw_pkg::DATA_W-1:0] pwdata,
    output logic [lcdw_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output lcdw_pkg::t_cfg             o_cfg
);
    import lcdw_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_phase_us       <= RST_ENABLE_PHASE;
            r_cfg.select_setup_us       <= RST_SELECT_SETUP;
            r_cfg.byte_gap_us           <= RST_BYTE_GAP;
            r_cfg.short_command_wait_us <= RST_SHORT_WAIT;
            r_cfg.long_command_wait_us  <= RST_LONG_WAIT;
            r_cfg.data_wait_us          <= RST_DATA_WAIT;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ENABLE_PHASE: r_cfg.enable_phase_us       <= pwdata[7:0];
                REG_SELECT_SETUP: r_cfg.select_setup_us       <= pwdata[15:0];
                REG_BYTE_GAP:     r_cfg.byte_gap_us           <= pwdata[15:0];
                REG_SHORT_WAIT:   r_cfg.short_command_wait_us <= pwdata[15:0];
                REG_LONG_WAIT:    r_cfg.long_command_wait_us  <= pwdata[15:0];
                REG_DATA_WAIT:    r_cfg.data_wait_us          <= pwdata[15:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ENABLE_PHASE: prdata = {24'd0, r_cfg.enable_phase_us};
            REG_SELECT_SETUP: prdata = {16'd0, r_cfg.select_setup_us};
            REG_BYTE_GAP:     prdata = {16'd0, r_cfg.byte_gap_us};
            REG_SHORT_WAIT:   prdata = {16'd0, r_cfg.short_command_wait_us};
            REG_LONG_WAIT:    prdata = {16'd0, r_cfg.long_command_wait_us};
            REG_DATA_WAIT:    prdata = {16'd0, r_cfg.data_wait_us};
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== hdl/lcdw_front.sv =====
// Front end: takes input requests, classifies the mode and queues them.
// Depends on lcdw_pkg and lcdw_fifo.
module lcdw_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [1:0]      i_mode,
    input  logic [7:0]      i_byte_value,
    output logic            o_full,
    output logic            o_item_valid,
    input  logic            i_item_pop,
    output lcdw_pkg::t_item o_item
);
    import lcdw_pkg::*;

    t_item w_item;
    logic  w_empty;

    always_comb begin
        unique case (i_mode)
            KIND_TICK: w_item.kind = KIND_TICK;
            KIND_CMD:  w_item.kind = KIND_CMD;
            KIND_DATA: w_item.kind = KIND_DATA;
            default:   w_item.kind = KIND_INIT;
        endcase
        w_item.byte_value = i_byte_value;
    end

    lcdw_fifo #(
        .WIDTH(ITEM_W)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_item),
        .o_full  (o_full),
        .i_pop   (i_item_pop),
        .o_empty (w_empty),
        .o_data  (o_item)
    );

    assign o_item_valid = !w_empty;

endmodule

// ===== hdl/lcdw_back.sv =====
// Back end: phase sequencer, wait counter and pin drive for the 4-bit bus.
// Depends on lcdw_pkg; runs one phase step per cycle when waits are zero.
module lcdw_back #(
    parameter int COUNTER_WIDTH = lcdw_pkg::COUNTER_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcdw_pkg::t_cfg    i_cfg,
    input  logic              i_item_valid,
    input  lcdw_pkg::t_item   i_item,
    output logic              o_item_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output lcdw_pkg::t_result o_result
);
    import lcdw_pkg::*;

    localparam logic [31:0] CMAX = (32'd1 << COUNTER_WIDTH) - 32'd1;

    t_phase                   r_phase, n_phase;
    logic [COUNTER_WIDTH-1:0] r_wait, n_wait;
    logic [7:0]               r_byte, n_byte;
    logic                     r_sel, n_sel;
    logic [3:0]               r_step, n_step;
    logic [4:0]               r_pins, n_pins;
    logic                     r_settle, n_settle;
    logic                     r_rej, n_rej;
    logic                     w_check;

    // saturate a 16-bit wait to the counter width
    function automatic logic [COUNTER_WIDTH-1:0] load(input logic [15:0] v);
        if (32'(v) > CMAX) begin
            return CMAX[COUNTER_WIDTH-1:0];
        end
        return COUNTER_WIDTH'(v);
    endfunction

    always_comb begin
        n_phase    = r_phase;
        n_wait     = r_wait;
        n_byte     = r_byte;
        n_sel      = r_sel;
        n_step     = r_step;
        n_pins     = r_pins;
        n_settle   = r_settle;
        n_rej      = r_rej;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        w_check    = 1'b0;

        if (r_settle) begin
            w_check = 1'b1;
            unique case (r_phase)
                PH_SETUP: begin
                    n_phase = PH_HI_A;
                    n_pins  = {1'b0, r_byte[7:4]};
                    n_wait  = load({8'd0, i_cfg.enable_phase_us});
                end
                PH_HI_A: begin
                    n_phase = PH_HI_B;
                    n_pins  = {1'b1, r_byte[7:4]};
                    n_wait  = load({8'd0, i_cfg.enable_phase_us});
                end
                PH_HI_B: begin
                    n_phase = PH_HI_C;
                    n_pins  = {1'b0, r_byte[7:4]};
                    n_wait  = load({8'd0, i_cfg.enable_phase_us});
                end
                PH_HI_C: begin
                    n_phase = PH_LO_A;
                    n_pins  = {1'b0, r_byte[3:0]};
                    n_wait  = load({8'd0, i_cfg.enable_phase_us});
                end
                PH_LO_A: begin
                    n_phase = PH_LO_B;
                    n_pins  = {1'b1, r_byte[3:0]};
                    n_wait  = load({8'd0, i_cfg.enable_phase_us});
                end
                PH_LO_B: begin
                    n_phase = PH_LO_C;
                    n_pins  = {1'b0, r_byte[3:0]};
                    n_wait  = load({8'd0, i_cfg.enable_phase_us});
                end
                PH_LO_C: begin
                    n_phase = PH_GAP;
                    n_wait  = load(i_cfg.byte_gap_us);
                end
                PH_GAP: begin
                    n_phase = PH_POST;
                    if (r_sel) begin
                        n_wait = load(i_cfg.data_wait_us);
                    end else if (r_byte < LONG_CMD_LIMIT) begin
                        n_wait = load(i_cfg.long_command_wait_us);
                    end else begin
                        n_wait = load(i_cfg.short_command_wait_us);
                    end
                end
                PH_POST: begin
                    if (r_step >= 4'd1 && r_step <= INIT_COUNT) begin
                        n_phase = PH_INIT_TAIL;
                        n_wait  = load(init_tail(3'(r_step - 4'd1)));
                    end else begin
                        n_step  = 4'd0;
                        n_phase = PH_IDLE;
                        n_wait  = '0;
                    end
                end
                PH_INIT_LEAD: begin
                    if (r_step >= 4'd1 && r_step <= INIT_COUNT) begin
                        n_byte  = init_cmd(3'(r_step - 4'd1));
                        n_sel   = 1'b0;
                        n_phase = PH_SETUP;
                        n_wait  = load(i_cfg.select_setup_us);
                    end else begin
                        n_step  = 4'd0;
                        n_phase = PH_IDLE;
                        n_wait  = '0;
                    end
                end
                PH_INIT_TAIL: begin
                    // next command of the sequence sits at the old step index
                    if (r_step >= 4'd1 && r_step < INIT_COUNT) begin
                        n_step  = r_step + 4'd1;
                        n_byte  = init_cmd(r_step[2:0]);
                        n_sel   = 1'b0;
                        n_phase = PH_SETUP;
                        n_wait  = load(i_cfg.select_setup_us);
                    end else begin
                        n_step  = 4'd0;
                        n_phase = PH_IDLE;
                        n_wait  = '0;
                    end
                end
                default: begin
                    n_step  = 4'd0;
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end
            endcase
        end else if (i_item_valid && !i_res_full) begin
            o_item_pop = 1'b1;
            w_check    = 1'b1;
            n_rej      = 1'b0;
            if (i_item.kind == KIND_TICK) begin
                if (r_phase != PH_IDLE && r_wait != '0) begin
                    n_wait = r_wait - COUNTER_WIDTH'(1);
                end
            end else if (r_phase != PH_IDLE) begin
                // refuse the request and leave the sequence untouched
                n_rej = 1'b1;
            end else begin
                unique case (i_item.kind) inside
                    KIND_CMD, KIND_DATA: begin
                        n_byte  = i_item.byte_value;
                        n_sel   = (i_item.kind == KIND_DATA);
                        n_phase = PH_SETUP;
                        n_wait  = load(i_cfg.select_setup_us);
                    end
                    default: begin
                        n_step  = 4'd1;
                        n_phase = PH_INIT_LEAD;
                        n_wait  = load(INIT_LEAD_US);
                    end
                endcase
            end
        end

        // a zero-length phase ends at once: step again before reporting
        if (w_check) begin
            if (n_phase != PH_IDLE && n_wait == '0) begin
                n_settle = 1'b1;
            end else begin
                n_settle   = 1'b0;
                o_res_push = 1'b1;
            end
        end
    end

    assign o_result.select_pin = n_sel;
    assign o_result.enable_pin = n_pins[4];
    assign o_result.bus_nibble = n_pins[3:0];
    assign o_result.busy_res   = (n_phase != PH_IDLE);
    assign o_result.rejected   = n_rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_wait   <= '0;
            r_byte   <= 8'd0;
            r_sel    <= 1'b0;
            r_step   <= 4'd0;
            r_pins   <= 5'd0;
            r_settle <= 1'b0;
            r_rej    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_wait   <= n_wait;
            r_byte   <= n_byte;
            r_sel    <= n_sel;
            r_step   <= n_step;
            r_pins   <= n_pins;
            r_settle <= n_settle;
            r_rej    <= n_rej;
        end
    end

`ifndef ASSERT_OFF
    a_settle_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settle |-> r_phase != PH_IDLE)
        else $error("settling while idle");
    a_busy_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_settle && r_phase != PH_IDLE) |-> r_wait != '0)
        else $error("busy phase left with zero wait");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into full queue");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= INIT_COUNT)
        else $error("init step out of range");
    a_no_pop_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settle |-> !o_item_pop)
        else $error("request taken during a settle step");
`endif

endmodule

// ===== hdl/char_lcd_nibble_write_sequencer.sv =====
// Character LCD write sequencer, 4-bit bus: one result per request.
// Each request passes the request queue and the phase stepper into the result queue, and
// the stepper runs through any zero-length phases before it reports the result.
// Throughput: one request per cycle while no zero-length phase is stepped through and the result queue has room.
// Reset: synchronous, active low; clears queues and sequencer, loads register defaults.
// Depends on lcdw_pkg, lcdw_regs, lcdw_front, lcdw_back and lcdw_fifo.
module char_lcd_nibble_write_sequencer #(
    parameter int COUNTER_WIDTH = lcdw_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcdw_pkg::ADDR_W-1:0] paddr,
    input  logic [lcdw_pkg::DATA_W-1:0] pwdata,
    output logic [lcdw_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_mode,
    input  logic [7:0]                  i_byte_value,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_select_pin,
    output logic                        o_enable_pin,
    output logic [3:0]                  o_bus_nibble,
    output logic                        o_busy_res,
    output logic                        o_rejected
);
    import lcdw_pkg::*;

    t_cfg    w_cfg;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_item_pop;
    logic    w_res_full;
    logic    w_res_push;
    t_result w_res_in;
    t_result w_res_out;

    lcdw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lcdw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_mode       (i_mode),
        .i_byte_value (i_byte_value),
        .o_full       (full),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop),
        .o_item       (w_item)
    );

    lcdw_back #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .i_res_full   (w_res_full),
        .o_res_push   (w_res_push),
        .o_result     (w_res_in)
    );

    lcdw_fifo #(
        .WIDTH(RESULT_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_out)
    );

    assign o_select_pin = w_res_out.select_pin;
    assign o_enable_pin = w_res_out.enable_pin;
    assign o_bus_nibble = w_res_out.bus_nibble;
    assign o_busy_res   = w_res_out.busy_res;
    assign o_rejected   = w_res_out.rejected;

endmodule
